FILE: design/gdrm_pkg.sv
package gdrm_pkg;

	localparam int MAX_RECO_DEF = 16;
	localparam int MAX_REF_DEF  = 16;
	localparam int OUT_LIMIT    = 16;
	localparam logic [25:0] RADIUS_SQ_RESET = 26'd271900;

	localparam logic [1:0] MODE_RECO  = 2'd0;
	localparam logic [1:0] MODE_REF   = 2'd1;
	localparam logic [1:0] MODE_RUN   = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_reco;
		logic load_ref;
		logic scan_start;
		logic scan_step;
		logic take_best;
		logic emit_start;
		logic emit_next;
		logic clear_event;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic scan_done;
		logic found;
		logic emit_last;
		logic no_reco;
	} dp_stat_t;

endpackage

FILE: design/gdrm_datapath.sv
module gdrm_datapath #(
	parameter int MAX_RECO = gdrm_pkg::MAX_RECO_DEF,
	parameter int MAX_REF  = gdrm_pkg::MAX_REF_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gdrm_pkg::dp_cmd_t  cmd,
	output gdrm_pkg::dp_stat_t stat,
	input  logic [25:0]        radius_sq_limit,
	input  logic signed [12:0] in_eta,
	input  logic [11:0]        in_phi,
	output logic [3:0]         out_reco_index,
	output logic [3:0]         out_ref_index,
	output logic               out_matched,
	output logic               out_last
);

	localparam int RI_W = (MAX_RECO > 1) ? $clog2(MAX_RECO) : 1;
	localparam int FI_W = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;
	localparam int RC_W = $clog2(MAX_RECO + 1);
	localparam int FC_W = $clog2(MAX_REF + 1);
	localparam int NOUT = (MAX_RECO < gdrm_pkg::OUT_LIMIT) ? MAX_RECO : gdrm_pkg::OUT_LIMIT;
	localparam int NO_W = $clog2(NOUT + 1);

	logic signed [12:0] reco_eta_q [MAX_RECO];
	logic [11:0]        reco_phi_q [MAX_RECO];
	logic signed [12:0] ref_eta_q  [MAX_REF];
	logic [11:0]        ref_phi_q  [MAX_REF];

	logic [RC_W-1:0]     reco_count_q;
	logic [FC_W-1:0]     ref_count_q;
	logic [MAX_RECO-1:0] reco_taken_q;
	logic [MAX_REF-1:0]  ref_taken_q;
	logic [MAX_RECO-1:0] assign_valid_q;
	logic [FI_W-1:0]     assignment_q [MAX_RECO];

	logic [RI_W-1:0] i_q;
	logic [FI_W-1:0] j_q;
	logic            found_q;
	logic [25:0]     best_q;
	logic [RI_W-1:0] bi_q;
	logic [FI_W-1:0] bj_q;
	logic            scan_done_q;

	// Pair stage 1: operands registered; stage 2: squared distance.
	logic signed [12:0] a_eta_s1, b_eta_s1;
	logic [11:0]        a_phi_s1, b_phi_s1;
	logic               ok_s1, last_s1;
	logic [RI_W-1:0]    i_s1;
	logic [FI_W-1:0]    j_s1;
	logic [26:0]        d_s2;
	logic               ok_s2, last_s2;
	logic [RI_W-1:0]    i_s2;
	logic [FI_W-1:0]    j_s2;

	logic [RC_W-1:0] emit_q;
	logic [NO_W-1:0] nout;

	logic signed [13:0] de;
	logic [13:0]        ade;
	logic [11:0]        dp_raw;
	logic [11:0]        dp;
	logic               pair_last;
	logic               pair_ok;

	assign nout = (reco_count_q > RC_W'(NOUT)) ? NO_W'(NOUT) : NO_W'(reco_count_q);
	assign pair_ok = (RC_W'(i_q) < reco_count_q) && (FC_W'(j_q) < ref_count_q)
		&& !reco_taken_q[i_q] && !ref_taken_q[j_q];
	assign pair_last = (j_q == FI_W'(MAX_REF - 1)) && (i_q == RI_W'(MAX_RECO - 1));

	always_comb begin
		de = 14'(a_eta_s1) - 14'(b_eta_s1);
		ade = de[13] ? 14'(-de) : 14'(de);
		dp_raw = a_phi_s1 - b_phi_s1;
		dp = (dp_raw > 12'd2048) ? 12'(13'd4096 - 13'(dp_raw)) : dp_raw;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_reco && reco_count_q < RC_W'(MAX_RECO)) begin
			reco_eta_q[reco_count_q[RI_W-1:0]] <= in_eta;
			reco_phi_q[reco_count_q[RI_W-1:0]] <= in_phi;
		end
		if (cmd.load_ref && ref_count_q < FC_W'(MAX_REF)) begin
			ref_eta_q[ref_count_q[FI_W-1:0]] <= in_eta;
			ref_phi_q[ref_count_q[FI_W-1:0]] <= in_phi;
		end
		a_eta_s1 <= reco_eta_q[i_q];
		a_phi_s1 <= reco_phi_q[i_q];
		b_eta_s1 <= ref_eta_q[j_q];
		b_phi_s1 <= ref_phi_q[j_q];
		i_s1 <= i_q;
		j_s1 <= j_q;
		d_s2 <= 27'(ade * ade) + 27'(dp * dp);
		i_s2 <= i_s1;
		j_s2 <= j_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reco_count_q <= '0;
			ref_count_q <= '0;
			reco_taken_q <= '0;
			ref_taken_q <= '0;
			assign_valid_q <= '0;
			i_q <= '0;
			j_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			bi_q <= '0;
			bj_q <= '0;
			scan_done_q <= 1'b0;
			ok_s1 <= 1'b0;
			last_s1 <= 1'b0;
			ok_s2 <= 1'b0;
			last_s2 <= 1'b0;
			emit_q <= '0;
			for (int k = 0; k < MAX_RECO; k++) assignment_q[k] <= '0;
		end else begin
			if (cmd.load_reco && reco_count_q < RC_W'(MAX_RECO))
				reco_count_q <= reco_count_q + 1'b1;
			if (cmd.load_ref && ref_count_q < FC_W'(MAX_REF))
				ref_count_q <= ref_count_q + 1'b1;

			ok_s1 <= 1'b0;
			last_s1 <= 1'b0;
			ok_s2 <= ok_s1;
			last_s2 <= last_s1;
			scan_done_q <= 1'b0;

			if (cmd.scan_start) begin
				i_q <= '0;
				j_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				ok_s1 <= pair_ok;
				last_s1 <= pair_last;
				if (j_q == FI_W'(MAX_REF - 1)) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end

			// Strict compares keep the first pair in scan order on ties.
			if (ok_s2 && d_s2 < 27'(radius_sq_limit) && (!found_q || d_s2 < 27'(best_q))) begin
				found_q <= 1'b1;
				best_q <= d_s2[25:0];
				bi_q <= i_s2;
				bj_q <= j_s2;
			end
			if (last_s2) scan_done_q <= 1'b1;

			if (cmd.take_best) begin
				reco_taken_q[bi_q] <= 1'b1;
				ref_taken_q[bj_q] <= 1'b1;
				assign_valid_q[bi_q] <= 1'b1;
				assignment_q[bi_q] <= bj_q;
			end

			if (cmd.emit_start) emit_q <= '0;
			else if (cmd.emit_next) emit_q <= emit_q + 1'b1;

			if (cmd.clear_event) begin
				reco_count_q <= '0;
				ref_count_q <= '0;
				reco_taken_q <= '0;
				ref_taken_q <= '0;
				assign_valid_q <= '0;
			end
		end
	end

	always_comb begin
		stat.scan_last = pair_last;
		stat.scan_done = scan_done_q;
		stat.found = found_q;
		stat.emit_last = (NO_W'(emit_q) + 1'b1 == nout);
		stat.no_reco = (reco_count_q == '0);
		out_reco_index = 4'(emit_q);
		out_matched = assign_valid_q[emit_q[RI_W-1:0]];
		out_ref_index = out_matched ? 4'(assignment_q[emit_q[RI_W-1:0]]) : 4'd0;
		out_last = stat.emit_last;
	end

endmodule

FILE: design/gdrm_ctrl.sv
module gdrm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_mode,
	output logic               out_load,
	input  logic               out_free,
	output gdrm_pkg::dp_cmd_t  cmd,
	input  gdrm_pkg::dp_stat_t stat
);

	gdrm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gdrm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		logic acc;
		acc = 1'b0;
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			gdrm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				acc = in_valid;
				if (acc) begin
					cmd.load_reco = (in_mode == gdrm_pkg::MODE_RECO);
					cmd.load_ref = (in_mode == gdrm_pkg::MODE_REF);
					if (in_mode == gdrm_pkg::MODE_RUN) begin
						cmd.scan_start = 1'b1;
						state_d = gdrm_pkg::ST_SCAN;
					end
				end
			end
			gdrm_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				// The last pair is issued; let the pipeline drain.
				if (stat.scan_last) state_d = gdrm_pkg::ST_WAIT;
			end
			gdrm_pkg::ST_WAIT: begin
				if (stat.scan_done) state_d = gdrm_pkg::ST_PICK;
			end
			gdrm_pkg::ST_PICK: begin
				if (stat.found) begin
					cmd.take_best = 1'b1;
					cmd.scan_start = 1'b1;
					state_d = gdrm_pkg::ST_SCAN;
				end else if (stat.no_reco) begin
					cmd.clear_event = 1'b1;
					state_d = gdrm_pkg::ST_IDLE;
				end else begin
					cmd.emit_start = 1'b1;
					state_d = gdrm_pkg::ST_EMIT;
				end
			end
			gdrm_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					cmd.emit_next = 1'b1;
					if (stat.emit_last) begin
						cmd.clear_event = 1'b1;
						state_d = gdrm_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = gdrm_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: design/greedy_delta_r_jet_matcher.sv
// Channel    Direction  Contents
// s_axis     in         tdata = mode[1:0], eta[14:2], phi[26:15]
// m_axis     out        tdata = reco_index[3:0], ref_index[7:4], matched[8]; tlast = last
// cfg        in         radius_sq_limit, written when cfg_we is high
// A run scans every reco/reference slot pair once per greedy selection, for up to
// MAX_RECO+1 passes, all through the single shared distance unit; then one result per
// reco jet, at most OUT_LIMIT.
// Reset clears the counts and flags and returns the limit to its default; jet
// stores are filled by loads.
// A stalled output holds the emit sequencer; input is not taken during a run.
module greedy_delta_r_jet_matcher #(
	parameter int MAX_RECO = gdrm_pkg::MAX_RECO_DEF,
	parameter int MAX_REF  = gdrm_pkg::MAX_REF_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // mode, eta, phi from the lowest bit up
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // reco_index, ref_index, matched from the lowest bit up
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [25:0] cfg_wdata
);

	logic [25:0] radius_q;
	gdrm_pkg::dp_cmd_t  cmd;
	gdrm_pkg::dp_stat_t stat;
	logic [3:0] r_idx, f_idx;
	logic       r_match, r_last, out_load, out_free;
	logic [8:0] obuf_q;
	logic       olast_q, ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) radius_q <= gdrm_pkg::RADIUS_SQ_RESET;
		else if (cfg_we) radius_q <= cfg_wdata;
	end

	gdrm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_mode(s_axis_tdata[1:0]),
		.out_load(out_load), .out_free(out_free),
		.cmd(cmd), .stat(stat)
	);

	gdrm_datapath #(.MAX_RECO(MAX_RECO), .MAX_REF(MAX_REF)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.radius_sq_limit(radius_q),
		.in_eta(s_axis_tdata[14:2]), .in_phi(s_axis_tdata[26:15]),
		.out_reco_index(r_idx), .out_ref_index(f_idx),
		.out_matched(r_match), .out_last(r_last)
	);

	// Output register: free when empty or being drained this cycle.
	assign out_free = !ovalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (out_free) ovalid_q <= out_load;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			obuf_q <= {r_match, f_idx, r_idx};
			olast_q <= r_last;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {7'd0, obuf_q};
	assign m_axis_tlast = olast_q;

endmodule
